@@ design/open_loop_sine_commutation_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the open-loop sine commutation block
// Each macro expands to one labeled concurrent assertion, sampled on the
// rising clock edge and disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef OPEN_LOOP_SINE_COMMUTATION_ASSERT_SVH
`define OPEN_LOOP_SINE_COMMUTATION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLSC_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OLSC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/olsc_pkg.sv @@
// ---------------------------------------------------------------------------
// olsc_pkg
// Types, constants and the sine table shared by the commutation block.
// ---------------------------------------------------------------------------
`default_nettype none

package olsc_pkg;

  // Field widths
  localparam int SENSOR_W     = 16;
  localparam int STATUS_W     = 2;
  localparam int ANGLE_W      = 9;
  localparam int ANGLE_SUM_W  = ANGLE_W + 1;
  localparam int VEL_W        = 36;
  localparam int DUTY_PORT_W  = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int POLE_W       = 7;
  localparam int TICK_W       = 16;
  localparam int AMP_W        = 16;
  localparam int TARGET_W     = 32;

  // Sine table and duty format
  localparam int SINE_ENTRIES   = 360;
  localparam int PHASE_V_OFFSET = 120;
  localparam int PHASE_W_OFFSET = 240;
  localparam int QUARTER_LEN    = 91;
  localparam int QIDX_W         = 7;
  localparam int QSINE_W        = 17;
  localparam int SINE_W         = QSINE_W + 1;
  localparam int PRODUCT_W      = AMP_W + SINE_W;
  localparam int DUTY_SUM_W     = PRODUCT_W + 1;
  localparam int DUTY_W         = 16;
  localparam int DUTY_SHIFT     = 32 - DUTY_W;
  localparam int DUTY_Q_W       = DUTY_SUM_W - DUTY_SHIFT;
  localparam logic [DUTY_W-1:0] DUTY_MAX = '1;
  localparam logic signed [DUTY_SUM_W-1:0] DUTY_BIAS =
      (DUTY_SUM_W'(1) << 31) + (DUTY_SUM_W'(1) << (DUTY_SHIFT - 1));
  localparam int NUM_PHASES     = 3;
  localparam int PHASE_IDX_W    = 2;
  localparam logic [PHASE_IDX_W-1:0] PHASE_LAST = PHASE_IDX_W'(NUM_PHASES - 1);

  // Velocity and step arithmetic
  localparam int DIFF_W       = SENSOR_W + 2;
  localparam int VEL_SCALE_W  = 20;
  localparam logic [VEL_SCALE_W-1:0] VEL_SCALE = VEL_SCALE_W'(1000000);
  localparam int VEL_PROD_W   = SENSOR_W + VEL_SCALE_W;
  localparam int PROD1_W      = TARGET_W + TICK_W;
  localparam int PROD2_W      = PROD1_W + POLE_W;
  // 256000000 = 2^11 * 125000: the power of two is a shift, the rest a divide.
  localparam int STEP_SHIFT   = 11;
  localparam int STEP_DIVISOR = 125000;

  // Shared iterative divider, two quotient bits per cycle
  localparam int DIV_W        = PROD2_W - STEP_SHIFT;
  localparam int DIV_DEN_W    = 17;
  localparam int DIV_STEPS    = DIV_W / 2;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_MODE      = 3'd1,
    CFG_POLES     = 3'd2,
    CFG_TARGET    = 3'd3,
    CFG_TICK      = 3'd4,
    CFG_AMPLITUDE = 3'd5
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_DISABLED = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    DIV_VEL  = 2'd0,
    DIV_STEP = 2'd1,
    DIV_MOD  = 2'd2
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_MUL2,
    S_VEL_DIV,
    S_STEP_DIV,
    S_MOD_DIV,
    S_ADVANCE,
    S_SINE,
    S_PRODUCT,
    S_DUTY,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     mul;
    logic     mul2;
    logic     div_start;
    div_sel_t div_sel;
    logic     vel_load;
    logic     advance;
    logic     sine;
    logic     product;
    logic     duty;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic angle_mode;
    logic div_busy;
    logic div_done;
    logic last_phase;
  } stat_t;

  // Quarter-wave sine, 65536 * sin(k degrees), k = 0..90
  localparam logic [QSINE_W-1:0] QUARTER_SINE [QUARTER_LEN] = '{
    17'd0, 17'd1144, 17'd2287, 17'd3430, 17'd4572, 17'd5712, 17'd6850, 17'd7987,
    17'd9121, 17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
    17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415, 17'd23486,
    17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753, 17'd30767,
    17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647, 17'd37590,
    17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995, 17'd43852,
    17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
    17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684, 17'd54332,
    17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865, 17'd58393,
    17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183, 17'd61584,
    17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589, 17'd63856,
    17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
    17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  // Full-circle sine for an angle of 0..359 degrees, built by symmetry.
  function automatic logic signed [SINE_W-1:0] sine_at(input logic [ANGLE_W-1:0] deg);
    logic [ANGLE_W-1:0] folded;
    logic               neg;
    logic [SINE_W-1:0]  mag;
    if (deg <= ANGLE_W'(90)) begin
      folded = deg;
      neg    = 1'b0;
    end else if (deg <= ANGLE_W'(180)) begin
      folded = ANGLE_W'(180) - deg;
      neg    = 1'b0;
    end else if (deg <= ANGLE_W'(270)) begin
      folded = deg - ANGLE_W'(180);
      neg    = 1'b1;
    end else begin
      folded = ANGLE_W'(SINE_ENTRIES) - deg;
      neg    = 1'b1;
    end
    mag = {1'b0, QUARTER_SINE[folded[QIDX_W-1:0]]};
    return neg ? $signed(-mag) : $signed(mag);
  endfunction

endpackage

`default_nettype wire

@@ design/olsc_sample_if.sv @@
// ---------------------------------------------------------------------------
// olsc_sample_if
// Valid/ready channel carrying one sensor reading per word.
// ---------------------------------------------------------------------------
`default_nettype none

interface olsc_sample_if;
  logic                          valid;
  logic                          ready;
  logic [olsc_pkg::SENSOR_W-1:0] sensor_angle;
  logic                          sensor_valid;

  modport source (output valid, output sensor_angle, output sensor_valid, input ready);
  modport sink   (input valid, input sensor_angle, input sensor_valid, output ready);
endinterface

`default_nettype wire

@@ design/olsc_result_if.sv @@
// ---------------------------------------------------------------------------
// olsc_result_if
// Valid/ready channel carrying one commutation result per word.
// ---------------------------------------------------------------------------
`default_nettype none

interface olsc_result_if;
  logic                             valid;
  logic                             ready;
  logic [olsc_pkg::STATUS_W-1:0]    status;
  logic                             phases_updated;
  logic [olsc_pkg::DUTY_PORT_W-1:0] duty_u;
  logic [olsc_pkg::DUTY_PORT_W-1:0] duty_v;
  logic [olsc_pkg::DUTY_PORT_W-1:0] duty_w;
  logic [olsc_pkg::ANGLE_W-1:0]     electrical_angle;
  logic signed [olsc_pkg::VEL_W-1:0] measured_velocity;

  modport source (output valid, output status, output phases_updated, output duty_u,
                  output duty_v, output duty_w, output electrical_angle,
                  output measured_velocity, input ready);
  modport sink   (input valid, input status, input phases_updated, input duty_u,
                  input duty_v, input duty_w, input electrical_angle,
                  input measured_velocity, output ready);
endinterface

`default_nettype wire

@@ design/olsc_div.sv @@
// ---------------------------------------------------------------------------
// olsc_div
// Unsigned restoring divider, two quotient bits per clock cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module olsc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [olsc_pkg::DIV_W-1:0]       dividend,
  input  logic [olsc_pkg::DIV_DEN_W-1:0]   divisor,
  output logic [olsc_pkg::DIV_W-1:0]       quotient,
  output logic [olsc_pkg::DIV_DEN_W-1:0]   remainder,
  output logic                             busy,
  output logic                             done
);

  logic [olsc_pkg::DIV_W-1:0]     quo;
  logic [olsc_pkg::DIV_W-1:0]     quo_next;
  logic [olsc_pkg::DIV_DEN_W-1:0] rem;
  logic [olsc_pkg::DIV_DEN_W-1:0] rem_next;
  logic [olsc_pkg::DIV_DEN_W-1:0] den;
  logic [olsc_pkg::DIV_CNT_W-1:0] count;

  logic [olsc_pkg::DIV_DEN_W:0]   trial1;
  logic [olsc_pkg::DIV_DEN_W:0]   trial2;
  logic [olsc_pkg::DIV_DEN_W:0]   diff1;
  logic [olsc_pkg::DIV_DEN_W:0]   diff2;
  logic                           ge1;
  logic                           ge2;
  logic [olsc_pkg::DIV_DEN_W-1:0] rem_mid;
  logic [olsc_pkg::DIV_W-1:0]     quo_mid;

  // The partial remainder stays below the divisor, so each trial fits one extra bit.
  always_comb begin
    trial1   = {rem, quo[olsc_pkg::DIV_W-1]};
    diff1    = trial1 - {1'b0, den};
    ge1      = trial1 >= {1'b0, den};
    rem_mid  = ge1 ? diff1[olsc_pkg::DIV_DEN_W-1:0] : trial1[olsc_pkg::DIV_DEN_W-1:0];
    quo_mid  = {quo[olsc_pkg::DIV_W-2:0], ge1};
    trial2   = {rem_mid, quo_mid[olsc_pkg::DIV_W-1]};
    diff2    = trial2 - {1'b0, den};
    ge2      = trial2 >= {1'b0, den};
    rem_next = ge2 ? diff2[olsc_pkg::DIV_DEN_W-1:0] : trial2[olsc_pkg::DIV_DEN_W-1:0];
    quo_next = {quo_mid[olsc_pkg::DIV_W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (count == olsc_pkg::DIV_CNT_W'(1));
      if (start) begin
        count <= olsc_pkg::DIV_CNT_W'(olsc_pkg::DIV_STEPS);
      end else if (count != '0) begin
        count <= count - olsc_pkg::DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (count != '0) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign busy      = (count != '0);

endmodule

`default_nettype wire

@@ design/olsc_dp.sv @@
// ---------------------------------------------------------------------------
// olsc_dp
// Datapath: configuration registers, velocity and step arithmetic, the
// electrical angle, three phase duties and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "open_loop_sine_commutation_assert.svh"

module olsc_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [olsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [olsc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [olsc_pkg::SENSOR_W-1:0]       sensor_angle,
  input  logic                                sensor_valid,
  input  olsc_pkg::cmd_t                      cmd,
  output olsc_pkg::stat_t                     st,
  output logic [olsc_pkg::STATUS_W-1:0]       status,
  output logic                                phases_updated,
  output logic [olsc_pkg::DUTY_PORT_W-1:0]    duty_u,
  output logic [olsc_pkg::DUTY_PORT_W-1:0]    duty_v,
  output logic [olsc_pkg::DUTY_PORT_W-1:0]    duty_w,
  output logic [olsc_pkg::ANGLE_W-1:0]        electrical_angle,
  output logic signed [olsc_pkg::VEL_W-1:0]   measured_velocity
);

  // Configuration
  logic                                enable;
  logic                                control_mode;
  logic [olsc_pkg::POLE_W-1:0]         pole_pairs;
  logic [olsc_pkg::TARGET_W-1:0]       target_velocity;
  logic [olsc_pkg::TICK_W-1:0]         tick_period_us;
  logic signed [olsc_pkg::AMP_W-1:0]   drive_amplitude;

  // Per-tick working registers
  olsc_pkg::status_t                   status_r;
  logic                                updated;
  logic [olsc_pkg::SENSOR_W-1:0]       in_angle;
  logic                                vel_neg;
  logic [olsc_pkg::VEL_PROD_W-1:0]     vel_prod;
  logic                                step_neg;
  logic [olsc_pkg::PROD1_W-1:0]        step_prod1;
  logic [olsc_pkg::PROD2_W-1:0]        step_prod2;
  logic signed [olsc_pkg::VEL_W-1:0]   velocity;
  logic [olsc_pkg::PHASE_IDX_W-1:0]    phase;
  logic signed [olsc_pkg::SINE_W-1:0]  sine_val;
  logic signed [olsc_pkg::PRODUCT_W-1:0] product;

  // State kept from tick to tick
  logic [olsc_pkg::SENSOR_W-1:0]       prev_angle;
  logic [olsc_pkg::ANGLE_W-1:0]        angle;
  logic [olsc_pkg::DUTY_W-1:0]         duty [olsc_pkg::NUM_PHASES];

  // Output register
  olsc_pkg::status_t                   out_status;
  logic                                out_updated;
  logic [olsc_pkg::DUTY_PORT_W-1:0]    out_duty_u;
  logic [olsc_pkg::DUTY_PORT_W-1:0]    out_duty_v;
  logic [olsc_pkg::DUTY_PORT_W-1:0]    out_duty_w;
  logic [olsc_pkg::ANGLE_W-1:0]        out_angle;
  logic signed [olsc_pkg::VEL_W-1:0]   out_velocity;

  // Divider connection
  logic [olsc_pkg::DIV_W-1:0]          div_dividend;
  logic [olsc_pkg::DIV_DEN_W-1:0]      div_divisor;
  logic [olsc_pkg::DIV_W-1:0]          div_quo;
  logic [olsc_pkg::DIV_DEN_W-1:0]      div_rem;
  logic                                div_busy;
  logic                                div_done;

  // Combinational helpers
  logic [olsc_pkg::TICK_W-1:0]         dt_eff;
  logic signed [olsc_pkg::DIFF_W-1:0]  diff_raw;
  logic signed [olsc_pkg::DIFF_W-1:0]  diff;
  logic [olsc_pkg::DIFF_W-1:0]         diff_neg;
  logic [olsc_pkg::SENSOR_W-1:0]       diff_mag;
  logic [olsc_pkg::TARGET_W-1:0]       target_mag;
  logic [olsc_pkg::VEL_W-1:0]          vel_quo;
  logic [olsc_pkg::ANGLE_W-1:0]        step_rem;
  logic [olsc_pkg::ANGLE_SUM_W-1:0]    adv_sum;
  logic [olsc_pkg::ANGLE_SUM_W-1:0]    adv_wrap;
  logic [olsc_pkg::ANGLE_SUM_W-1:0]    ph_offset;
  logic [olsc_pkg::ANGLE_SUM_W-1:0]    ph_sum;
  logic [olsc_pkg::ANGLE_SUM_W-1:0]    ph_wrap;
  logic signed [olsc_pkg::DUTY_SUM_W-1:0] duty_sum;
  logic [olsc_pkg::DUTY_Q_W-1:0]       duty_top;
  logic [olsc_pkg::DUTY_W-1:0]         duty_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= 1'b0;
      control_mode    <= 1'b0;
      pole_pairs      <= olsc_pkg::POLE_W'(1);
      target_velocity <= '0;
      tick_period_us  <= olsc_pkg::TICK_W'(1000);
      drive_amplitude <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        olsc_pkg::CFG_ENABLE:    enable          <= cfg_wdata[0];
        olsc_pkg::CFG_MODE:      control_mode    <= cfg_wdata[0];
        olsc_pkg::CFG_POLES:     pole_pairs      <= cfg_wdata[olsc_pkg::POLE_W-1:0];
        olsc_pkg::CFG_TARGET:    target_velocity <= cfg_wdata[olsc_pkg::TARGET_W-1:0];
        olsc_pkg::CFG_TICK:      tick_period_us  <= cfg_wdata[olsc_pkg::TICK_W-1:0];
        olsc_pkg::CFG_AMPLITUDE: drive_amplitude <= $signed(cfg_wdata[olsc_pkg::AMP_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    dt_eff   = (tick_period_us == '0) ? olsc_pkg::TICK_W'(1) : tick_period_us;

    // Sensor delta wrapped into a half turn either way.
    diff_raw = $signed({2'b00, in_angle}) - $signed({2'b00, prev_angle});
    if (diff_raw > olsc_pkg::DIFF_W'(32768)) begin
      diff = diff_raw - olsc_pkg::DIFF_W'(65536);
    end else if (diff_raw < -$signed(olsc_pkg::DIFF_W'(32768))) begin
      diff = diff_raw + olsc_pkg::DIFF_W'(65536);
    end else begin
      diff = diff_raw;
    end
    diff_neg = -diff;
    diff_mag = diff[olsc_pkg::DIFF_W-1] ? diff_neg[olsc_pkg::SENSOR_W-1:0]
                                        : diff[olsc_pkg::SENSOR_W-1:0];

    target_mag = target_velocity[olsc_pkg::TARGET_W-1] ? (~target_velocity + 1'b1)
                                                       : target_velocity;

    case (cmd.div_sel)
      olsc_pkg::DIV_VEL: begin
        div_dividend = olsc_pkg::DIV_W'(vel_prod);
        div_divisor  = olsc_pkg::DIV_DEN_W'(dt_eff);
      end
      olsc_pkg::DIV_STEP: begin
        div_dividend = step_prod2[olsc_pkg::PROD2_W-1:olsc_pkg::STEP_SHIFT];
        div_divisor  = olsc_pkg::DIV_DEN_W'(olsc_pkg::STEP_DIVISOR);
      end
      olsc_pkg::DIV_MOD: begin
        div_dividend = div_quo;
        div_divisor  = olsc_pkg::DIV_DEN_W'(olsc_pkg::SINE_ENTRIES);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = olsc_pkg::DIV_DEN_W'(1);
      end
    endcase

    vel_quo = div_quo[olsc_pkg::VEL_W-1:0];

    // A backward step of r degrees is a forward step of 360 - r.
    step_rem = div_rem[olsc_pkg::ANGLE_W-1:0];
    if (step_neg) begin
      adv_sum = {1'b0, angle} + (olsc_pkg::ANGLE_SUM_W'(olsc_pkg::SINE_ENTRIES)
                                 - {1'b0, step_rem});
    end else begin
      adv_sum = {1'b0, angle} + {1'b0, step_rem};
    end
    adv_wrap = (adv_sum >= olsc_pkg::ANGLE_SUM_W'(olsc_pkg::SINE_ENTRIES))
             ? adv_sum - olsc_pkg::ANGLE_SUM_W'(olsc_pkg::SINE_ENTRIES) : adv_sum;

    case (phase)
      2'd1:    ph_offset = olsc_pkg::ANGLE_SUM_W'(olsc_pkg::PHASE_V_OFFSET);
      2'd2:    ph_offset = olsc_pkg::ANGLE_SUM_W'(olsc_pkg::PHASE_W_OFFSET);
      default: ph_offset = '0;
    endcase
    ph_sum  = {1'b0, angle} + ph_offset;
    ph_wrap = (ph_sum >= olsc_pkg::ANGLE_SUM_W'(olsc_pkg::SINE_ENTRIES))
            ? ph_sum - olsc_pkg::ANGLE_SUM_W'(olsc_pkg::SINE_ENTRIES) : ph_sum;

    // Half scale plus the scaled sine, rounded half up; never negative.
    duty_sum = olsc_pkg::DUTY_BIAS + olsc_pkg::DUTY_SUM_W'(product);
    duty_top = duty_sum[olsc_pkg::DUTY_SUM_W-1:olsc_pkg::DUTY_SHIFT];
    duty_sat = (duty_top > olsc_pkg::DUTY_Q_W'(olsc_pkg::DUTY_MAX))
             ? olsc_pkg::DUTY_MAX : duty_top[olsc_pkg::DUTY_W-1:0];
  end

  olsc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .busy      (div_busy),
    .done      (div_done)
  );

  // Control-visible and kept state
  always_ff @(posedge clk) begin
    if (rst) begin
      status_r   <= olsc_pkg::ST_DISABLED;
      updated    <= 1'b0;
      phase      <= '0;
      prev_angle <= '0;
      angle      <= '0;
      for (int i = 0; i < olsc_pkg::NUM_PHASES; i++) begin
        duty[i] <= '0;
      end
    end else begin
      if (cmd.capture) begin
        updated <= 1'b0;
        if (!enable) begin
          status_r <= olsc_pkg::ST_DISABLED;
        end else if (!sensor_valid) begin
          status_r <= olsc_pkg::ST_INVALID;
        end else begin
          status_r <= olsc_pkg::ST_OK;
        end
      end
      if (cmd.mul) begin
        prev_angle <= in_angle;
      end
      if (cmd.advance) begin
        angle   <= adv_wrap[olsc_pkg::ANGLE_W-1:0];
        phase   <= '0;
        updated <= 1'b1;
      end
      if (cmd.duty) begin
        duty[phase] <= duty_sat;
        phase       <= phase + 1'b1;
      end
    end
  end

  // Arithmetic payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_angle <= sensor_angle;
      velocity <= '0;
    end
    if (cmd.mul) begin
      vel_neg    <= diff[olsc_pkg::DIFF_W-1];
      vel_prod   <= diff_mag * olsc_pkg::VEL_SCALE;
      step_neg   <= target_velocity[olsc_pkg::TARGET_W-1];
      step_prod1 <= target_mag * dt_eff;
    end
    if (cmd.mul2) begin
      step_prod2 <= step_prod1 * pole_pairs;
    end
    if (cmd.vel_load) begin
      velocity <= vel_neg ? $signed(-vel_quo) : $signed(vel_quo);
    end
    if (cmd.sine) begin
      sine_val <= olsc_pkg::sine_at(ph_wrap[olsc_pkg::ANGLE_W-1:0]);
    end
    if (cmd.product) begin
      product <= drive_amplitude * sine_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status   <= status_r;
      out_updated  <= updated;
      out_duty_u   <= olsc_pkg::DUTY_PORT_W'(duty[0]);
      out_duty_v   <= olsc_pkg::DUTY_PORT_W'(duty[1]);
      out_duty_w   <= olsc_pkg::DUTY_PORT_W'(duty[2]);
      out_angle    <= angle;
      out_velocity <= velocity;
    end
  end

  assign st.active     = (status_r == olsc_pkg::ST_OK);
  assign st.angle_mode = control_mode;
  assign st.div_busy   = div_busy;
  assign st.div_done   = div_done;
  assign st.last_phase = (phase == olsc_pkg::PHASE_LAST);

  assign status            = out_status;
  assign phases_updated    = out_updated;
  assign duty_u            = out_duty_u;
  assign duty_v            = out_duty_v;
  assign duty_w            = out_duty_w;
  assign electrical_angle  = out_angle;
  assign measured_velocity = out_velocity;

  `OLSC_ASSERT_NOW(a_angle_range, clk, rst, 1'b1, angle < olsc_pkg::ANGLE_W'(olsc_pkg::SINE_ENTRIES), "commutation angle left 0..359")
  `OLSC_ASSERT_NOW(a_mod_range, clk, rst, cmd.advance, div_rem < olsc_pkg::DIV_DEN_W'(olsc_pkg::SINE_ENTRIES), "step remainder not below 360")
  `OLSC_ASSERT_NOW(a_updated_ok, clk, rst, cmd.out_load && updated, status_r == olsc_pkg::ST_OK, "phases updated on a tick that was not ok")

endmodule

`default_nettype wire

@@ design/olsc_ctrl.sv @@
// ---------------------------------------------------------------------------
// olsc_ctrl
// Controller: sequences one control tick through the datapath and owns the
// handshakes of both channels.
// ---------------------------------------------------------------------------
`default_nettype none

`include "open_loop_sine_commutation_assert.svh"

module olsc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            sample_valid,
  output logic            sample_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  olsc_pkg::stat_t st,
  output olsc_pkg::cmd_t  cmd
);

  olsc_pkg::state_t state;
  olsc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= olsc_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      olsc_pkg::S_IDLE:     if (sample_valid) state_next = olsc_pkg::S_CHECK;
      olsc_pkg::S_CHECK:    state_next = st.active ? olsc_pkg::S_MUL : olsc_pkg::S_FINISH;
      olsc_pkg::S_MUL:      state_next = olsc_pkg::S_MUL2;
      olsc_pkg::S_MUL2:     state_next = olsc_pkg::S_VEL_DIV;
      olsc_pkg::S_VEL_DIV: begin
        if (st.div_done) begin
          state_next = st.angle_mode ? olsc_pkg::S_FINISH : olsc_pkg::S_STEP_DIV;
        end
      end
      olsc_pkg::S_STEP_DIV: if (st.div_done) state_next = olsc_pkg::S_MOD_DIV;
      olsc_pkg::S_MOD_DIV:  if (st.div_done) state_next = olsc_pkg::S_ADVANCE;
      olsc_pkg::S_ADVANCE:  state_next = olsc_pkg::S_SINE;
      olsc_pkg::S_SINE:     state_next = olsc_pkg::S_PRODUCT;
      olsc_pkg::S_PRODUCT:  state_next = olsc_pkg::S_DUTY;
      olsc_pkg::S_DUTY:     state_next = st.last_phase ? olsc_pkg::S_FINISH : olsc_pkg::S_SINE;
      olsc_pkg::S_FINISH:   if (!out_valid || out_ready) state_next = olsc_pkg::S_IDLE;
      default:              state_next = olsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.div_sel  = olsc_pkg::DIV_VEL;
    sample_ready = 1'b0;
    case (state)
      olsc_pkg::S_IDLE: begin
        sample_ready = 1'b1;
        cmd.capture  = sample_valid;
      end
      olsc_pkg::S_MUL: begin
        cmd.mul = 1'b1;
      end
      olsc_pkg::S_MUL2: begin
        cmd.mul2      = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = olsc_pkg::DIV_VEL;
      end
      olsc_pkg::S_VEL_DIV: begin
        cmd.vel_load  = st.div_done;
        cmd.div_start = st.div_done && !st.angle_mode;
        cmd.div_sel   = olsc_pkg::DIV_STEP;
      end
      olsc_pkg::S_STEP_DIV: begin
        // The step quotient feeds straight back as the next dividend.
        cmd.div_start = st.div_done;
        cmd.div_sel   = olsc_pkg::DIV_MOD;
      end
      olsc_pkg::S_ADVANCE: begin
        cmd.advance = 1'b1;
      end
      olsc_pkg::S_SINE: begin
        cmd.sine = 1'b1;
      end
      olsc_pkg::S_PRODUCT: begin
        cmd.product = 1'b1;
      end
      olsc_pkg::S_DUTY: begin
        cmd.duty = 1'b1;
      end
      olsc_pkg::S_FINISH: begin
        cmd.out_load = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  `OLSC_ASSERT_NOW(a_div_idle, clk, rst, cmd.div_start, !st.div_busy, "divider started while busy")
  `OLSC_ASSERT_NOW(a_out_from_finish, clk, rst, $rose(out_valid), $past(state == olsc_pkg::S_FINISH), "result word appeared outside the finish step")
  `OLSC_ASSERT_NEXT(a_finish_holds, clk, rst, state == olsc_pkg::S_FINISH && out_valid && !out_ready, state == olsc_pkg::S_FINISH, "finished word dropped while output stalled")

endmodule

`default_nettype wire

@@ design/open_loop_sine_commutation.sv @@
// ---------------------------------------------------------------------------
// open_loop_sine_commutation
// Open-loop sinusoidal commutation for a three-phase BLDC drive.
// ---------------------------------------------------------------------------
// Each sample word is one control tick and yields exactly one result word.
// A disabled block or an invalid reading is reported with nothing changed. A
// good reading measures the shaft velocity with one division by the tick
// period; angle open-loop mode then finishes. In velocity open-loop mode two
// more divisions (step size, then modulo 360) advance the electrical angle,
// and the three phase duties are computed one after another on a single
// multiplier, each through the sine, product and duty steps. The shared
// divider retires two quotient bits per cycle. The next sample word is taken
// while the previous result still waits in the output register.
`default_nettype none

module open_loop_sine_commutation (
  input  logic                            clk,
  input  logic                            rst,
  olsc_sample_if.sink                     sample,
  olsc_result_if.source                   result,
  input  logic                            cfg_we,
  input  logic [olsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [olsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  olsc_pkg::cmd_t  cmd;
  olsc_pkg::stat_t st;

  olsc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .st           (st),
    .cmd          (cmd)
  );

  olsc_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .sensor_angle      (sample.sensor_angle),
    .sensor_valid      (sample.sensor_valid),
    .cmd               (cmd),
    .st                (st),
    .status            (result.status),
    .phases_updated    (result.phases_updated),
    .duty_u            (result.duty_u),
    .duty_v            (result.duty_v),
    .duty_w            (result.duty_w),
    .electrical_angle  (result.electrical_angle),
    .measured_velocity (result.measured_velocity)
  );

endmodule

`default_nettype wire
